### rtl/gbn_pkg.sv
// package: constants, codes and shared types of the go-back-n sender window
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

   localparam int SEQ_BITS = 16;
   localparam int WINDOW_MAX = 64;
   localparam int TIME_BITS = 32;

   localparam int SLOT_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_BITS = (SEQ_BITS > 16) ? SEQ_BITS : 16;

   localparam int CMD_BITS = 2;
   localparam int ACK_SEQ_BITS = 16;
   localparam int SEND_SEQ_BITS = 16;
   localparam int IN_FLIGHT_BITS = 7;
   localparam int WINDOW_CFG_BITS = 7;
   localparam int TIMEOUT_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [WINDOW_CFG_BITS-1:0] WINDOW_RESET = WINDOW_CFG_BITS'(8);
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK = 2'd0,
      CMD_NEW  = 2'd1,
      CMD_ACK  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE   = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      logic [TIME_BITS-1:0] wr_data;
   } mem_req_type;

endpackage
`default_nettype wire

### rtl/gbn_if.sv
// interfaces: request, response and register write channels
`timescale 1ns / 1ps
`default_nettype none
interface gbn_req_if;
   import gbn_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_BITS-1:0]     command;
   logic [ACK_SEQ_BITS-1:0] ack_seq;
   modport source (output valid, output command, output ack_seq, input ready);
   modport sink (input valid, input command, input ack_seq, output ready);
endinterface

interface gbn_rsp_if;
   import gbn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      send_valid;
   logic [SEND_SEQ_BITS-1:0]  send_seq;
   logic                      went_back;
   logic                      ack_accepted;
   logic                      new_dropped;
   logic [IN_FLIGHT_BITS-1:0] in_flight;
   modport source (output valid, output send_valid, output send_seq, output went_back,
                   output ack_accepted, output new_dropped, output in_flight,
                   input ready);
   modport sink (input valid, input send_valid, input send_seq, input went_back,
                 input ack_accepted, input new_dropped, input in_flight,
                 output ready);
endinterface

interface gbn_csr_if;
   import gbn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/gbn_dl_mem.sv
// deadline store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module gbn_dl_mem (
   input  wire logic                          clock,
   input  wire gbn_pkg::mem_req_type          mem_req,
   output logic [gbn_pkg::TIME_BITS-1:0]      rd_data
);
   import gbn_pkg::*;

   logic [TIME_BITS-1:0] mem_array [WINDOW_MAX];
   logic [TIME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_array[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/gbn_ctrl.sv
// sequencer: counters, timeout check, send decision and response register
`timescale 1ns / 1ps
`default_nettype none
module gbn_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [gbn_pkg::CMD_BITS-1:0]        req_command,
   input  wire logic [gbn_pkg::ACK_SEQ_BITS-1:0]    req_ack_seq,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_send_valid,
   output logic [gbn_pkg::SEND_SEQ_BITS-1:0]        rsp_send_seq,
   output logic                                     rsp_went_back,
   output logic                                     rsp_ack_accepted,
   output logic                                     rsp_new_dropped,
   output logic [gbn_pkg::IN_FLIGHT_BITS-1:0]       rsp_in_flight,
   input  wire logic [gbn_pkg::WINDOW_CFG_BITS-1:0] window_size,
   input  wire logic [gbn_pkg::TIMEOUT_BITS-1:0]    timeout_ticks,
   output gbn_pkg::mem_req_type                     mem_req,
   input  wire logic [gbn_pkg::TIME_BITS-1:0]       mem_rd_data
);
   import gbn_pkg::*;

   localparam logic [SEQ_BITS-1:0] SEQ_ONES = '1;

   function automatic logic [SLOT_BITS-1:0] slot_inc(
      input logic [SLOT_BITS-1:0] slot,
      input logic [SEQ_BITS-1:0]  seq
   );
      logic [SLOT_BITS-1:0] res;
      if (seq == SEQ_ONES || 32'(slot) == WINDOW_MAX - 1) begin
         res = '0;
      end else begin
         res = slot + SLOT_BITS'(1);
      end
      return res;
   endfunction

   ctl_state_type state_ff, state_in;

   logic [SEQ_BITS-1:0]     oldest_ff, oldest_in;
   logic [SEQ_BITS-1:0]     next_send_ff, next_send_in;
   logic [SEQ_BITS-1:0]     next_new_ff, next_new_in;
   logic [SLOT_BITS-1:0]    oldest_slot_ff, oldest_slot_in;
   logic [SLOT_BITS-1:0]    send_slot_ff, send_slot_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   cmd_type                 cmd_ff;
   logic [ACK_SEQ_BITS-1:0] ack_seq_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      send_valid_ff, send_valid_in;
   logic [SEND_SEQ_BITS-1:0]  send_seq_ff, send_seq_in;
   logic                      went_back_ff, went_back_in;
   logic                      ack_accepted_ff, ack_accepted_in;
   logic                      new_dropped_ff, new_dropped_in;
   logic [IN_FLIGHT_BITS-1:0] in_flight_ff, in_flight_in;

   logic accept;
   logic exec_go;

   logic [SEQ_BITS-1:0]  win_used;
   logic [SEQ_BITS-1:0]  flight_pre;
   logic [SEQ_BITS-1:0]  flight_mid;
   logic [SEQ_BITS-1:0]  flight_post;
   logic [TIME_BITS-1:0] time_diff;
   logic [SEQ_BITS-1:0]  ns_mid;
   logic [SLOT_BITS-1:0] ns_slot_mid;
   logic                 send_now;

   assign accept = req_valid && req_ready;
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         oldest_ff      <= '0;
         next_send_ff   <= '0;
         next_new_ff    <= '0;
         oldest_slot_ff <= '0;
         send_slot_ff   <= '0;
         time_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         oldest_ff      <= oldest_in;
         next_send_ff   <= next_send_in;
         next_new_ff    <= next_new_in;
         oldest_slot_ff <= oldest_slot_in;
         send_slot_ff   <= send_slot_in;
         time_ff        <= time_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= cmd_type'(req_command);
         ack_seq_ff <= req_ack_seq;
      end
      if (exec_go) begin
         send_valid_ff   <= send_valid_in;
         send_seq_ff     <= send_seq_in;
         went_back_ff    <= went_back_in;
         ack_accepted_ff <= ack_accepted_in;
         new_dropped_ff  <= new_dropped_in;
         in_flight_ff    <= in_flight_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      oldest_in       = oldest_ff;
      next_send_in    = next_send_ff;
      next_new_in     = next_new_ff;
      oldest_slot_in  = oldest_slot_ff;
      send_slot_in    = send_slot_ff;
      time_in         = time_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      send_valid_in   = 1'b0;
      send_seq_in     = '0;
      went_back_in    = 1'b0;
      ack_accepted_in = 1'b0;
      new_dropped_in  = 1'b0;
      in_flight_in    = '0;
      req_ready       = (state_ff == ST_IDLE);
      ns_mid          = next_send_ff;
      ns_slot_mid     = send_slot_ff;
      send_now        = 1'b0;
      time_diff       = '0;
      flight_mid      = '0;
      flight_post     = '0;

      mem_req.rd_en   = accept;
      mem_req.rd_addr = oldest_slot_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = send_slot_ff;
      mem_req.wr_data = '0;

      if (32'(window_size) > WINDOW_MAX) begin
         win_used = SEQ_BITS'(WINDOW_MAX);
      end else begin
         win_used = SEQ_BITS'(window_size);
      end
      flight_pre = next_send_ff - oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_TICK: begin
                  time_in = time_ff + TIME_BITS'(1);
                  time_diff = time_in - mem_rd_data;
                  if (flight_pre != '0 && !time_diff[TIME_BITS-1]) begin
                     ns_mid       = oldest_ff;
                     ns_slot_mid  = oldest_slot_ff;
                     went_back_in = 1'b1;
                  end
               end
               CMD_NEW: begin
                  if ((next_new_ff - oldest_ff) == SEQ_ONES) begin
                     new_dropped_in = 1'b1;
                  end else begin
                     next_new_in = next_new_ff + SEQ_BITS'(1);
                  end
               end
               CMD_ACK: begin
                  if (flight_pre != '0 &&
                      CMP_BITS'(ack_seq_ff) == CMP_BITS'(oldest_ff)) begin
                     oldest_in       = oldest_ff + SEQ_BITS'(1);
                     oldest_slot_in  = slot_inc(oldest_slot_ff, oldest_ff);
                     ack_accepted_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            flight_mid = ns_mid - oldest_in;
            send_now = (ns_mid != next_new_in) && (flight_mid < win_used);
            mem_req.wr_addr = ns_slot_mid;
            mem_req.wr_data = time_in + TIME_BITS'(timeout_ticks);
            next_send_in = ns_mid;
            send_slot_in = ns_slot_mid;
            if (send_now) begin
               send_valid_in = 1'b1;
               send_seq_in   = SEND_SEQ_BITS'(ns_mid);
               next_send_in  = ns_mid + SEQ_BITS'(1);
               send_slot_in  = slot_inc(ns_slot_mid, ns_mid);
            end
            flight_post  = next_send_in - oldest_in;
            in_flight_in = flight_post[IN_FLIGHT_BITS-1:0];

            if (exec_go) begin
               mem_req.wr_en = send_now;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               oldest_in      = oldest_ff;
               next_send_in   = next_send_ff;
               next_new_in    = next_new_ff;
               oldest_slot_in = oldest_slot_ff;
               send_slot_in   = send_slot_ff;
               time_in        = time_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_send_valid   = send_valid_ff;
   assign rsp_send_seq     = send_seq_ff;
   assign rsp_went_back    = went_back_ff;
   assign rsp_ack_accepted = ack_accepted_ff;
   assign rsp_new_dropped  = new_dropped_ff;
   assign rsp_in_flight    = in_flight_ff;

endmodule
`default_nettype wire

### rtl/go_back_n_sender_window.sv
// Go-back-N sender window controller, top level.
// req_bus takes one item per transfer: command (tick, new packet,
// acknowledgement, or no-op) and ack_seq. rsp_bus returns exactly one
// result per item: send_valid/send_seq for the packet sent after the item,
// went_back on a timeout rewind, ack_accepted, new_dropped and in_flight.
// csr_bus writes window_size (index 0) and timeout_ticks (index 1); it is
// always ready and is meant to be written only while the block is idle.
// An item passes the idle and execute states: on acceptance the oldest
// packet's deadline is read from the registered deadline memory; in the
// execute state the block updates the counters, writes the deadline of the
// packet sent and loads the response register. A new item is accepted only
// in the idle state, once the previous item has left the execute state.
// A result waiting on rsp_bus does not block the next item from being
// accepted; that item is then held in the execute state until the pending
// response transfers. Reset clears the counters, the time counter and the
// response valid, and restores window_size 8 and timeout_ticks 100; the
// deadline memory is not cleared, only entries of packets in flight are used.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_window (
   input wire logic  clock,
   input wire logic  reset,
   gbn_req_if.sink   req_bus,
   gbn_rsp_if.source rsp_bus,
   gbn_csr_if.sink   csr_bus
);
   import gbn_pkg::*;

   logic [WINDOW_CFG_BITS-1:0] window_ff, window_in;
   logic [TIMEOUT_BITS-1:0]    timeout_ff, timeout_in;
   mem_req_type                mem_req;
   logic [TIME_BITS-1:0]       mem_rd_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      window_in  = window_ff;
      timeout_in = timeout_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_WINDOW_SIZE:   window_in = csr_bus.data[WINDOW_CFG_BITS-1:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr_bus.data[TIMEOUT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         window_ff  <= window_in;
         timeout_ff <= timeout_in;
      end
   end

   gbn_dl_mem u_gbn_dl_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   gbn_ctrl u_gbn_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_command      (req_bus.command),
      .req_ack_seq      (req_bus.ack_seq),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_send_valid   (rsp_bus.send_valid),
      .rsp_send_seq     (rsp_bus.send_seq),
      .rsp_went_back    (rsp_bus.went_back),
      .rsp_ack_accepted (rsp_bus.ack_accepted),
      .rsp_new_dropped  (rsp_bus.new_dropped),
      .rsp_in_flight    (rsp_bus.in_flight),
      .window_size      (window_ff),
      .timeout_ticks    (timeout_ff),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

endmodule
`default_nettype wire

### rtl/gbn_checker.sv
// checker on the top level ports, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gbn_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                send_valid,
   input wire logic [gbn_pkg::SEND_SEQ_BITS-1:0]   send_seq,
   input wire logic                                went_back,
   input wire logic                                ack_accepted,
   input wire logic                                new_dropped,
   input wire logic [gbn_pkg::IN_FLIGHT_BITS-1:0]  in_flight
);
   import gbn_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(send_seq))
      else $error("stalled response changed");

   a_idle_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !send_valid |-> send_seq == '0)
      else $error("sequence number without a send");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({went_back, ack_accepted, new_dropped}))
      else $error("more than one item outcome flagged");

   a_send_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_valid && WINDOW_MAX < 128 |-> in_flight != '0)
      else $error("packet sent but nothing in flight");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .send_valid   (rsp_bus.send_valid),
   .send_seq     (rsp_bus.send_seq),
   .went_back    (rsp_bus.went_back),
   .ack_accepted (rsp_bus.ack_accepted),
   .new_dropped  (rsp_bus.new_dropped),
   .in_flight    (rsp_bus.in_flight)
);
`default_nettype wire

### verif/go_back_n_sender_window_tb.sv
// testbench for the go-back-n sender window: directed table, random phases
`timescale 1ns / 1ps
module go_back_n_sender_window_tb;
   import gbn_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 360;

   typedef struct packed {
      logic                      send_valid;
      logic [SEND_SEQ_BITS-1:0]  send_seq;
      logic                      went_back;
      logic                      ack_accepted;
      logic                      new_dropped;
      logic [IN_FLIGHT_BITS-1:0] in_flight;
   } window_result_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [ACK_SEQ_BITS-1:0] ack;
      logic                    typed;
      window_result_type       want;
   } dir_row_type;

   logic clock;
   logic reset;

   gbn_req_if req_bus ();
   gbn_rsp_if rsp_bus ();
   gbn_csr_if csr_bus ();

   go_back_n_sender_window DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted sender state
   logic [SEQ_BITS-1:0]        oldest_seq;
   logic [SEQ_BITS-1:0]        send_ptr;
   logic [SEQ_BITS-1:0]        new_ptr;
   logic [TIME_BITS-1:0]       tick_count;
   logic [TIME_BITS-1:0]       deadline_mem [WINDOW_MAX];
   logic [WINDOW_CFG_BITS-1:0] window_reg;
   logic [TIMEOUT_BITS-1:0]    timeout_reg;

   window_result_type window_outcomes [$];
   dir_row_type       directed_rows [$];
   int                mismatch_count;
   int                stuck_cycles;
   int                sender_idle_pct;
   int                receiver_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic window_result_type advance_window(input cmd_type cmd,
                                                        input logic [ACK_SEQ_BITS-1:0] ack);
      window_result_type    r;
      logic [SEQ_BITS-1:0]  flight;
      logic [TIME_BITS-1:0] age;
      int unsigned          win;
      r = '0;
      win = (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
      case (cmd)
         CMD_TICK: begin
            tick_count = tick_count + 1'b1;
            if (send_ptr != oldest_seq) begin
               age = tick_count - deadline_mem[oldest_seq % WINDOW_MAX];
               if (!age[TIME_BITS-1]) begin
                  send_ptr = oldest_seq;
                  r.went_back = 1'b1;
               end
            end
         end
         CMD_NEW: begin
            if (SEQ_BITS'(new_ptr - oldest_seq) == {SEQ_BITS{1'b1}}) r.new_dropped = 1'b1;
            else new_ptr = new_ptr + 1'b1;
         end
         CMD_ACK: begin
            if (send_ptr != oldest_seq && CMP_BITS'(ack) == CMP_BITS'(oldest_seq)) begin
               oldest_seq = oldest_seq + 1'b1;
               r.ack_accepted = 1'b1;
            end
         end
         default: ;
      endcase
      flight = send_ptr - oldest_seq;
      if (send_ptr != new_ptr && flight < win) begin
         deadline_mem[send_ptr % WINDOW_MAX] = tick_count + timeout_reg;
         r.send_valid = 1'b1;
         r.send_seq = send_ptr[SEND_SEQ_BITS-1:0];
         send_ptr = send_ptr + 1'b1;
      end
      flight = send_ptr - oldest_seq;
      r.in_flight = flight[IN_FLIGHT_BITS-1:0];
      return r;
   endfunction

   function automatic dir_row_type row(input cmd_type cmd, input logic [ACK_SEQ_BITS-1:0] ack,
                                       input logic typed, input logic sv,
                                       input logic [SEND_SEQ_BITS-1:0] seq, input logic aa,
                                       input logic [IN_FLIGHT_BITS-1:0] infl);
      dir_row_type d;
      d = '0;
      d.cmd = cmd;
      d.ack = ack;
      d.typed = typed;
      d.want.send_valid = sv;
      d.want.send_seq = seq;
      d.want.ack_accepted = aa;
      d.want.in_flight = infl;
      return d;
   endfunction

   task automatic send_item(input cmd_type cmd, input logic [ACK_SEQ_BITS-1:0] ack,
                            input logic typed, input window_result_type want);
      window_result_type predicted;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.ack_seq <= ack;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predicted = advance_window(cmd, ack);
      window_outcomes.push_back(typed ? want : predicted);
   endtask

   // stop sending and let every outstanding transfer come back
   task automatic settle_window();
      req_bus.valid <= 1'b0;
      while (window_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_BITS-1:0] win_data,
                             input logic [CSR_DATA_BITS-1:0] timeout_data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_WINDOW_SIZE;
      csr_bus.data <= win_data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.index <= CSR_TIMEOUT_TICKS;
      csr_bus.data <= timeout_data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
      window_reg = win_data[WINDOW_CFG_BITS-1:0];
      timeout_reg = timeout_data[TIMEOUT_BITS-1:0];
   endtask

   task automatic run_random_phase(input logic [CSR_DATA_BITS-1:0] win_data,
                                   input logic [CSR_DATA_BITS-1:0] timeout_data,
                                   input int idle_pct, input int stall_pct);
      int                      r;
      cmd_type                 cmd;
      logic [ACK_SEQ_BITS-1:0] ack;
      settle_window();
      write_regs(win_data, timeout_data);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 2) settle_window();
         r = $urandom_range(99);
         if (r < 35) cmd = CMD_TICK;
         else if (r < 63) cmd = CMD_NEW;
         else if (r < 95) cmd = CMD_ACK;
         else cmd = CMD_NONE;
         ack = ACK_SEQ_BITS'($urandom_range(16'hFFFF));
         // mostly acknowledge the oldest packet, otherwise leave random noise
         if (cmd == CMD_ACK && send_ptr != oldest_seq && $urandom_range(99) < 85)
            ack = oldest_seq[ACK_SEQ_BITS-1:0];
         send_item(cmd, ack, 1'b0, '0);
      end
   endtask

   task automatic note_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h actual %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (window_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer");
         end else begin
            want = window_outcomes.pop_front();
            note_field("send_valid", want.send_valid, rsp_bus.send_valid);
            note_field("send_seq", want.send_seq, rsp_bus.send_seq);
            note_field("went_back", want.went_back, rsp_bus.went_back);
            note_field("ack_accepted", want.ack_accepted, rsp_bus.ack_accepted);
            note_field("new_dropped", want.new_dropped, rsp_bus.new_dropped);
            note_field("in_flight", want.in_flight, rsp_bus.in_flight);
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_NONE;
      req_bus.ack_seq <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_WINDOW_SIZE;
      csr_bus.data <= '0;
      mismatch_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      oldest_seq = '0;
      send_ptr = '0;
      new_ptr = '0;
      tick_count = '0;
      window_reg = WINDOW_RESET;
      timeout_reg = TIMEOUT_RESET;
      for (int i = 0; i < WINDOW_MAX; i++) deadline_mem[i] = '0;

      directed_rows = '{
         row(CMD_TICK, 16'h0000, 1'b1, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_ACK,  16'h0000, 1'b1, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NONE, 16'hFFFF, 1'b1, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b1, 1'b1, 16'd0, 1'b0, 7'd1),
         row(CMD_ACK,  16'hFFFF, 1'b1, 1'b0, 16'd0, 1'b0, 7'd1),
         row(CMD_ACK,  16'h0000, 1'b1, 1'b0, 16'd0, 1'b1, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NEW,  16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_ACK,  16'h0001, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_ACK,  16'hAAAA, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_ACK,  16'h5555, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_TICK, 16'hFFFF, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_NONE, 16'h0000, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0),
         row(CMD_ACK,  16'h0002, 1'b0, 1'b0, 16'd0, 1'b0, 7'd0)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of both registers are in force here
      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].ack, directed_rows[i].typed,
                   directed_rows[i].want);

      run_random_phase(16'h0004, 16'd1, 0, 0);
      run_random_phase(16'h0040, 16'd20, 72, 0);
      run_random_phase(16'h007F, 16'd0, 0, 72);
      run_random_phase(16'hFF81, 16'hFFFF, 25, 25);
      run_random_phase(16'h0010, 16'd3, 0, 0);

      settle_window();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && window_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/gbn_pkg.sv
rtl/gbn_if.sv
rtl/gbn_dl_mem.sv
rtl/gbn_ctrl.sv
rtl/go_back_n_sender_window.sv
rtl/gbn_checker.sv
verif/go_back_n_sender_window_tb.sv
